/* rtl/core/scr_pkg.sv */
package scr_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned ENTRY_W    = 48;

  localparam logic [31:0] RING_DEPTH_W = 32'(RING_DEPTH);

  localparam logic [15:0] MIN_PERIOD_RST = 16'd961;
  localparam logic [15:0] NOM_PERIOD_RST = 16'd1201;

  // deviation bucket upper limits, inclusive
  localparam logic [31:0] DEV_LIM0 = 32'd5;
  localparam logic [31:0] DEV_LIM1 = 32'd15;
  localparam logic [31:0] DEV_LIM2 = 32'd35;
  localparam logic [31:0] DEV_LIM3 = 32'd75;

  localparam int unsigned NUM_BUCKETS = 5;

  localparam logic [1:0] CFG_MIN_PERIOD = 2'd0;
  localparam logic [1:0] CFG_NOM_PERIOD = 2'd1;
  localparam logic [1:0] CFG_STATS_EN   = 2'd2;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_RING  = 2'd1,
    CMD_STAT  = 2'd2,
    CMD_CLEAR = 2'd3
  } scr_cmd_e;

  typedef enum logic [1:0] {
    OUT_STORED = 2'd0,
    OUT_GLITCH = 2'd1,
    OUT_RDERR  = 2'd2,
    OUT_NONE   = 2'd3
  } scr_outcome_e;

  typedef enum logic [3:0] {
    STAT_EVENTS  = 4'd0,
    STAT_LATE    = 4'd1,
    STAT_RDERR   = 4'd2,
    STAT_GLITCH  = 4'd3,
    STAT_DTCOUNT = 4'd4,
    STAT_DTMIN   = 4'd5,
    STAT_DTMAX   = 4'd6,
    STAT_DTSUM   = 4'd7,
    STAT_MAXDEV  = 4'd8,
    STAT_BUCKET0 = 4'd9,
    STAT_BUCKET1 = 4'd10,
    STAT_BUCKET2 = 4'd11,
    STAT_BUCKET3 = 4'd12,
    STAT_BUCKET4 = 4'd13
  } scr_stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_APPLY,
    ST_DEV,
    ST_RESP
  } scr_state_e;

  typedef struct packed {
    logic [15:0] min_period;
    logic [15:0] nominal_period;
    logic        stats_en;
  } scr_cfg_t;

  typedef struct packed {
    logic        calc;
    logic        apply;
    logic        dev;
    logic        is_event;
    logic        clear;
    logic        read_ok;
    logic        late_edge;
    logic [31:0] time_us;
  } scr_stat_ctrl_t;

endpackage

/* rtl/core/scr_ring_mem.sv */
module scr_ring_mem (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [scr_pkg::RING_AW-1:0]       waddr_i,
  input  logic [scr_pkg::ENTRY_W-1:0]       wdata_i,
  input  logic                              re_i,
  input  logic [scr_pkg::RING_AW-1:0]       raddr_i,
  output logic [scr_pkg::ENTRY_W-1:0]       rdata_o
);
  import scr_pkg::*;

  logic [ENTRY_W-1:0] mem [RING_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/scr_stats.sv */
module scr_stats (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scr_pkg::scr_cfg_t      cfg_i,
  input  scr_pkg::scr_stat_ctrl_t ctrl_i,
  input  logic [3:0]             stat_select_i,
  output logic                   glitch_o,
  output logic [31:0]            head_o,
  output logic [31:0]            stat_value_o
);
  import scr_pkg::*;

  logic [31:0] head_q, event_q, late_q, error_q, glitch_cnt_q;
  logic [31:0] last_time_q;
  logic        have_last_q;
  logic [31:0] icount_q, imin_q, imax_q, isum_q, worst_q;
  logic [31:0] bucket_q [NUM_BUCKETS];

  logic        glitch_q, upd_q;
  logic [31:0] dt_q, d_q;

  logic [31:0] dt_d;
  logic        glitch_d;
  logic [31:0] dev;
  logic [2:0]  bucket_sel;

  // wrapping interval, read as signed against the gate
  always_comb begin
    dt_d     = ctrl_i.time_us - last_time_q;
    glitch_d = ctrl_i.is_event && have_last_q &&
               (dt_d[31] || (dt_d < {16'b0, cfg_i.min_period}));
  end

  always_comb begin
    dev = d_q[31] ? (32'd0 - d_q) : d_q;
    priority if (dev <= DEV_LIM0) begin
      bucket_sel = 3'd0;
    end else if (dev <= DEV_LIM1) begin
      bucket_sel = 3'd1;
    end else if (dev <= DEV_LIM2) begin
      bucket_sel = 3'd2;
    end else if (dev <= DEV_LIM3) begin
      bucket_sel = 3'd3;
    end else begin
      bucket_sel = 3'd4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc) begin
      dt_q <= dt_d;
    end
    if (ctrl_i.apply) begin
      d_q <= dt_q - {16'b0, cfg_i.nominal_period};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glitch_q <= 1'b0;
      upd_q    <= 1'b0;
    end else if (ctrl_i.calc) begin
      glitch_q <= glitch_d;
      upd_q    <= ctrl_i.is_event && have_last_q && !glitch_d && cfg_i.stats_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      event_q      <= '0;
      late_q       <= '0;
      error_q      <= '0;
      glitch_cnt_q <= '0;
      last_time_q  <= '0;
      have_last_q  <= 1'b0;
      icount_q     <= '0;
      imin_q       <= '0;
      imax_q       <= '0;
      isum_q       <= '0;
      worst_q      <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_q[i] <= '0;
      end
    end else if (ctrl_i.apply && ctrl_i.clear) begin
      head_q       <= '0;
      event_q      <= '0;
      late_q       <= '0;
      error_q      <= '0;
      glitch_cnt_q <= '0;
      last_time_q  <= '0;
      have_last_q  <= 1'b0;
      icount_q     <= '0;
      imin_q       <= '0;
      imax_q       <= '0;
      isum_q       <= '0;
      worst_q      <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_q[i] <= '0;
      end
    end else if (ctrl_i.apply && ctrl_i.is_event) begin
      if (glitch_q) begin
        glitch_cnt_q <= glitch_cnt_q + 32'd1;
      end else begin
        last_time_q <= ctrl_i.time_us;
        have_last_q <= 1'b1;
        event_q     <= event_q + 32'd1;
        if (ctrl_i.late_edge) begin
          late_q <= late_q + 32'd1;
        end
        if (!ctrl_i.read_ok) begin
          error_q <= error_q + 32'd1;
        end else begin
          head_q <= head_q + 32'd1;
        end
      end
      if (upd_q) begin
        if (icount_q == '0 || dt_q < imin_q) begin
          imin_q <= dt_q;
        end
        if (icount_q == '0 || dt_q > imax_q) begin
          imax_q <= dt_q;
        end
        isum_q   <= isum_q + dt_q;
        icount_q <= icount_q + 32'd1;
      end
    end else if (ctrl_i.dev && upd_q) begin
      if (dev > worst_q) begin
        worst_q <= dev;
      end
      bucket_q[bucket_sel] <= bucket_q[bucket_sel] + 32'd1;
    end
  end

  always_comb begin
    unique case (scr_stat_e'(stat_select_i))
      STAT_EVENTS:  stat_value_o = event_q;
      STAT_LATE:    stat_value_o = late_q;
      STAT_RDERR:   stat_value_o = error_q;
      STAT_GLITCH:  stat_value_o = glitch_cnt_q;
      STAT_DTCOUNT: stat_value_o = icount_q;
      STAT_DTMIN:   stat_value_o = imin_q;
      STAT_DTMAX:   stat_value_o = imax_q;
      STAT_DTSUM:   stat_value_o = isum_q;
      STAT_MAXDEV:  stat_value_o = worst_q;
      STAT_BUCKET0: stat_value_o = bucket_q[0];
      STAT_BUCKET1: stat_value_o = bucket_q[1];
      STAT_BUCKET2: stat_value_o = bucket_q[2];
      STAT_BUCKET3: stat_value_o = bucket_q[3];
      STAT_BUCKET4: stat_value_o = bucket_q[4];
      default:      stat_value_o = '0;
    endcase
  end

  assign glitch_o = glitch_q;
  assign head_o   = head_q;

endmodule

/* rtl/core/sample_ready_capture_ring.sv */
// channel  dir  handshake                 payload
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in   in_valid_i / in_ready_o    cmd_i .. stat_select_i
// out      out  out_valid_o / out_ready_i  outcome_o .. stat_value_o
//
// one transaction at a time: accept, interval calc and ring read issue,
// apply (ring write), deviation update, result load
// the result sits in an output register while the next transaction enters
// a stalled output holds the sequencer in its result step
// asynchronous active-low reset clears counters, statistics and config
// to their defaults; the ring is not cleared and needs no sweep
module sample_ready_capture_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] time_us_i,
  input  logic [15:0] sample_in_i,
  input  logic        read_ok_i,
  input  logic        late_edge_i,
  input  logic [31:0] snapshot_i,
  input  logic [9:0]  entry_index_i,
  input  logic [3:0]  stat_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic [31:0] head_now_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_time_o,
  output logic [15:0] entry_value_o,
  output logic [31:0] stat_value_o
);
  import scr_pkg::*;

  scr_state_e state_q, state_d;
  scr_cfg_t   cfg_q;

  scr_cmd_e    cmd_q;
  logic [31:0] time_q, snapshot_q;
  logic [15:0] sample_q;
  logic        read_ok_q, late_edge_q;
  logic [9:0]  entry_index_q;
  logic [3:0]  stat_select_q;

  logic        ent_valid_q;
  logic        ent_valid_d;
  logic [RING_AW-1:0] rd_addr;

  logic        accept, calc, apply, dev, resp;
  logic        resp_load;
  logic        mem_we;
  logic [ENTRY_W-1:0] mem_rdata;

  scr_stat_ctrl_t stat_ctrl;
  logic        glitch;
  logic [31:0] head;
  logic [31:0] stat_value;

  logic         out_valid_q;
  scr_outcome_e outcome_q;
  logic [31:0]  head_now_q, entry_time_q, stat_value_q;
  logic         entry_valid_q;
  logic [15:0]  entry_value_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period     <= MIN_PERIOD_RST;
      cfg_q.nominal_period <= NOM_PERIOD_RST;
      cfg_q.stats_en       <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_PERIOD: cfg_q.min_period     <= cfg_data_i;
        CFG_NOM_PERIOD: cfg_q.nominal_period <= cfg_data_i;
        CFG_STATS_EN:   cfg_q.stats_en       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CALC;
      ST_CALC:  state_d = ST_APPLY;
      ST_APPLY: state_d = ST_DEV;
      ST_DEV:   state_d = ST_RESP;
      ST_RESP:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    calc       = (state_q == ST_CALC);
    apply      = (state_q == ST_APPLY);
    dev        = (state_q == ST_DEV);
    resp       = (state_q == ST_RESP);
  end

  assign accept    = in_valid_i && in_ready_o;
  assign resp_load = resp && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q         <= scr_cmd_e'(cmd_i);
      time_q        <= time_us_i;
      sample_q      <= sample_in_i;
      read_ok_q     <= read_ok_i;
      late_edge_q   <= late_edge_i;
      snapshot_q    <= snapshot_i;
      entry_index_q <= entry_index_i;
      stat_select_q <= stat_select_i;
    end
    if (calc) begin
      ent_valid_q <= ent_valid_d;
    end
  end

  // ring read address relative to the oldest entry retained at the snapshot
  always_comb begin
    if (|snapshot_q[31:RING_AW]) begin
      ent_valid_d = {22'b0, entry_index_q} < RING_DEPTH_W;
      rd_addr     = snapshot_q[RING_AW-1:0] + RING_AW'(entry_index_q);
    end else begin
      ent_valid_d = {22'b0, entry_index_q} < snapshot_q;
      rd_addr     = RING_AW'(entry_index_q);
    end
    ent_valid_d = ent_valid_d && (cmd_q == CMD_RING);
  end

  // writes land in apply, reads of later transactions come no earlier than calc
  assign mem_we = apply && (cmd_q == CMD_EVENT) && !glitch && read_ok_q;

  scr_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (head[RING_AW-1:0]),
    .wdata_i ({time_q, sample_q}),
    .re_i    (calc),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    stat_ctrl.calc      = calc;
    stat_ctrl.apply     = apply;
    stat_ctrl.dev       = dev;
    stat_ctrl.is_event  = (cmd_q == CMD_EVENT);
    stat_ctrl.clear     = (cmd_q == CMD_CLEAR);
    stat_ctrl.read_ok   = read_ok_q;
    stat_ctrl.late_edge = late_edge_q;
    stat_ctrl.time_us   = time_q;
  end

  scr_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ctrl_i        (stat_ctrl),
    .stat_select_i (stat_select_q),
    .glitch_o      (glitch),
    .head_o        (head),
    .stat_value_o  (stat_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      if (cmd_q != CMD_EVENT) begin
        outcome_q <= OUT_NONE;
      end else if (glitch) begin
        outcome_q <= OUT_GLITCH;
      end else if (!read_ok_q) begin
        outcome_q <= OUT_RDERR;
      end else begin
        outcome_q <= OUT_STORED;
      end
      head_now_q    <= head;
      entry_valid_q <= ent_valid_q;
      entry_time_q  <= ent_valid_q ? mem_rdata[ENTRY_W-1:16] : 32'd0;
      entry_value_q <= ent_valid_q ? mem_rdata[15:0] : 16'd0;
      stat_value_q  <= (cmd_q == CMD_STAT) ? stat_value : 32'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign head_now_o    = head_now_q;
  assign entry_valid_o = entry_valid_q;
  assign entry_time_o  = entry_time_q;
  assign entry_value_o = entry_value_q;
  assign stat_value_o  = stat_value_q;

endmodule

/* rtl/core/scr_checker.sv */
module scr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  outcome_o,
  input logic [31:0] head_now_o,
  input logic        entry_valid_o,
  input logic [31:0] entry_time_o,
  input logic [15:0] entry_value_o,
  input logic [31:0] stat_value_o
);
  import scr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(outcome_o) && $stable(head_now_o) &&
      $stable(entry_valid_o) && $stable(entry_time_o) &&
      $stable(entry_value_o) && $stable(stat_value_o))
    else $error("result changed while stalled");

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_ring_read_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> outcome_o == OUT_NONE)
    else $error("ring entry reported on an event");

  a_event_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_NONE) |->
      !entry_valid_o && (entry_time_o == '0) && (entry_value_o == '0) &&
      (stat_value_o == '0))
    else $error("event result carries read fields");

endmodule

bind sample_ready_capture_ring scr_checker u_scr_checker (.*);
